// File: rtl/core/nir_pkg.sv
// nir_pkg: shared types and constants of the nec ir frame decoder
// depends on nothing; used by the interfaces and every rtl module
`default_nettype none

package nir_pkg;

    // field widths
    localparam int unsigned TICK_W      = 24;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_BITS  = 32;
    localparam int unsigned BIT_CNT_W   = 6;
    localparam int unsigned CFG_INDEX_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ZERO_MIN   = 8'd0,
        CFG_ZERO_MAX   = 8'd1,
        CFG_LEADER_MIN = 8'd2,
        CFG_LEADER_MAX = 8'd3
    } cfg_index_t;

    // configuration reset values
    localparam logic [TICK_W-1:0] ZERO_MIN_RESET   = 24'd33750;
    localparam logic [TICK_W-1:0] ZERO_MAX_RESET   = 24'd56250;
    localparam logic [TICK_W-1:0] LEADER_MIN_RESET = 24'd520000;
    localparam logic [TICK_W-1:0] LEADER_MAX_RESET = 24'd599999;

    // classified edge passed from front to back
    typedef struct packed {
        logic leader_hit;
        logic zero_hit;
    } edge_token_t;

endpackage

`default_nettype wire

// File: rtl/core/nir_if.sv
// nir_if: valid/ready channel interfaces for edges, results and config writes
// depends on nir_pkg for field widths
`default_nettype none

interface nir_edge_if;
    logic                           valid;
    logic                           ready;
    logic [nir_pkg::TICK_W-1:0]     edge_interval;

    modport source (output valid, output edge_interval, input ready);
    modport sink   (input valid, input edge_interval, output ready);
endinterface

interface nir_result_if;
    logic                           valid;
    logic                           ready;
    logic [nir_pkg::BYTE_W-1:0]     address;
    logic [nir_pkg::BYTE_W-1:0]     address_inverse;
    logic [nir_pkg::BYTE_W-1:0]     command;
    logic [nir_pkg::BYTE_W-1:0]     command_inverse;
    logic                           frame_ok;

    modport source (output valid, output address, output address_inverse,
                    output command, output command_inverse, output frame_ok,
                    input ready);
    modport sink   (input valid, input address, input address_inverse,
                    input command, input command_inverse, input frame_ok,
                    output ready);
endinterface

interface nir_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [nir_pkg::CFG_INDEX_W-1:0]    index;
    logic [nir_pkg::TICK_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/nir_front.sv
// nir_front: configuration registers and window classification of each edge
// depends on nir_pkg and nir_if
`default_nettype none

module nir_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    nir_edge_if.sink                edge_ch,
    nir_cfg_if.sink                 cfg_ch,
    input  wire logic               queue_ready,
    output logic                    push,
    output nir_pkg::edge_token_t    push_token
);

    logic [nir_pkg::TICK_W-1:0] zero_min_reg;
    logic [nir_pkg::TICK_W-1:0] zero_max_reg;
    logic [nir_pkg::TICK_W-1:0] leader_min_reg;
    logic [nir_pkg::TICK_W-1:0] leader_max_reg;

    // config writes are always taken
    assign cfg_ch.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_min_reg   <= nir_pkg::ZERO_MIN_RESET;
            zero_max_reg   <= nir_pkg::ZERO_MAX_RESET;
            leader_min_reg <= nir_pkg::LEADER_MIN_RESET;
            leader_max_reg <= nir_pkg::LEADER_MAX_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                nir_pkg::CFG_ZERO_MIN:   zero_min_reg   <= cfg_ch.data;
                nir_pkg::CFG_ZERO_MAX:   zero_max_reg   <= cfg_ch.data;
                nir_pkg::CFG_LEADER_MIN: leader_min_reg <= cfg_ch.data;
                nir_pkg::CFG_LEADER_MAX: leader_max_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // accept an edge whenever the queue has room
    assign edge_ch.ready = queue_ready;
    assign push          = edge_ch.valid && queue_ready;

    // inclusive window compares
    always_comb
    begin
        push_token.zero_hit   = (edge_ch.edge_interval >= zero_min_reg) &&
                                (edge_ch.edge_interval <= zero_max_reg);
        push_token.leader_hit = (edge_ch.edge_interval >= leader_min_reg) &&
                                (edge_ch.edge_interval <= leader_max_reg);
    end

endmodule

`default_nettype wire

// File: rtl/core/nir_queue.sv
// nir_queue: small fifo of classified edges between front and back
// depends on nir_pkg for the token type
`default_nettype none

module nir_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire nir_pkg::edge_token_t push_token,
    output logic                    push_ready,
    input  wire logic               pop,
    output logic                    pop_valid,
    output nir_pkg::edge_token_t    pop_token
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nir_pkg::edge_token_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_token  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nir_back.sv
// nir_back: frame state machine, bit shifter and result register
// depends on nir_pkg and nir_if
`default_nettype none

module nir_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tok_valid,
    input  wire nir_pkg::edge_token_t tok,
    output logic                    pop,
    nir_result_if.source            result_ch
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ARMED,
        MODE_RECV
    } mode_t;

    localparam logic [nir_pkg::BIT_CNT_W-1:0] LAST_BIT =
        nir_pkg::BIT_CNT_W'(nir_pkg::FRAME_BITS - 1);

    mode_t                                  mode_reg;
    mode_t                                  mode_next;
    logic [nir_pkg::BIT_CNT_W-1:0]          bit_cnt_reg;
    logic [nir_pkg::BIT_CNT_W-1:0]          bit_cnt_next;
    logic [nir_pkg::FRAME_BITS-1:0]         shift_reg;
    logic [nir_pkg::FRAME_BITS-1:0]         shift_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [nir_pkg::FRAME_BITS-1:0]         frame_reg;
    logic [nir_pkg::FRAME_BITS-1:0]         frame_next;
    logic                                   ok_reg;
    logic                                   ok_next;
    logic [nir_pkg::FRAME_BITS-1:0]         shifted;
    logic                                   slot_free;

    // take a token whenever the result slot is empty or draining
    assign slot_free = !out_valid_reg || result_ch.ready;
    assign pop       = tok_valid && slot_free;

    // new bit enters at the top, lsb first on the wire
    assign shifted = {!tok.zero_hit, shift_reg[nir_pkg::FRAME_BITS-1:1]};

    // next state
    always_comb
    begin
        mode_next      = mode_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        frame_next     = frame_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        if (pop)
        begin
            case (mode_reg)
                MODE_ARMED:
                begin
                    if (tok.leader_hit)
                    begin
                        mode_next    = MODE_RECV;
                        bit_cnt_next = '0;
                        shift_next   = '0;
                    end
                end
                MODE_RECV:
                begin
                    shift_next   = shifted;
                    bit_cnt_next = bit_cnt_reg + nir_pkg::BIT_CNT_W'(1);
                    if (bit_cnt_reg == LAST_BIT)
                    begin
                        mode_next      = MODE_IDLE;
                        bit_cnt_next   = '0;
                        frame_next     = shifted;
                        ok_next        = (shifted[7:0]   == ~shifted[15:8]) &&
                                         (shifted[23:16] == ~shifted[31:24]);
                        out_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next    = MODE_ARMED;
                    bit_cnt_next = '0;
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
            frame_reg     <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
            frame_reg     <= frame_next;
            ok_reg        <= ok_next;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.address         = frame_reg[7:0];
    assign result_ch.address_inverse = frame_reg[15:8];
    assign result_ch.command         = frame_reg[23:16];
    assign result_ch.command_inverse = frame_reg[31:24];
    assign result_ch.frame_ok        = ok_reg;

endmodule

`default_nettype wire

// File: rtl/core/nec_ir_frame_decoder_core.sv
// nec ir frame decoder top: one edge transaction per cycle while the edge queue has room
// a frame result is valid once its final edge has passed through the edge queue
// (window compare writes the edge queue, state machine pops it and loads the result register)
// throughput: 1 edge per cycle, bounded by the result register draining
// reset: config registers take their default windows, decoder idle, queue empty
// depends on nir_pkg, nir_if, nir_front, nir_queue, nir_back
`default_nettype none

module nec_ir_frame_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nir_edge_if.sink        edge_ch,
    nir_cfg_if.sink         cfg_ch,
    nir_result_if.source    result_ch
);

    logic                   push;
    logic                   push_ready;
    logic                   pop;
    logic                   pop_valid;
    nir_pkg::edge_token_t   push_token;
    nir_pkg::edge_token_t   pop_token;

    // classify edges against the windows
    nir_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_ch     (edge_ch),
        .cfg_ch      (cfg_ch),
        .queue_ready (push_ready),
        .push        (push),
        .push_token  (push_token)
    );

    // decouple front and back
    nir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_token  (pop_token)
    );

    // frame assembly and result
    nir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (pop_valid),
        .tok       (pop_token),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

// File: tb/nir_frame_checker.sv
`timescale 1ns / 100ps
// nir_frame_checker: watches the edge, config and result channels of the ir decoder,
// predicts every frame result and compares it field by field
// depends on nir_pkg and the channel interfaces in nir_if
module nir_frame_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nir_edge_if         edge_ch,
    nir_cfg_if          cfg_ch,
    nir_result_if       result_ch,
    output int unsigned mismatch_count,
    output int unsigned frames_pending,
    output int unsigned frames_received
);
    import nir_pkg::*;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_ARMED,
        DEC_RECEIVING,
        DEC_UNUSED
    } dec_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] address_inverse;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] command_inverse;
        logic              frame_ok;
    } frame_t;

    // predicted decoder state and window registers
    logic [TICK_W-1:0]     zero_lo;
    logic [TICK_W-1:0]     zero_hi;
    logic [TICK_W-1:0]     leader_lo;
    logic [TICK_W-1:0]     leader_hi;
    dec_state_t            dec_state;
    logic [BIT_CNT_W-1:0]  bits_taken;
    logic [FRAME_BITS-1:0] shift_reg;
    frame_t                frames_due[$];

    initial
    begin
        mismatch_count  = 0;
        frames_pending  = 0;
        frames_received = 0;
    end

    // one falling edge through the predicted decoder
    task automatic decode_edge(input logic [TICK_W-1:0] ticks);
        frame_t f;
        logic   one_bit;
        case (dec_state)
            DEC_ARMED:
            begin
                if (ticks >= leader_lo && ticks <= leader_hi)
                begin
                    dec_state  = DEC_RECEIVING;
                    bits_taken = '0;
                    shift_reg  = '0;
                end
            end
            DEC_RECEIVING:
            begin
                one_bit    = !(ticks >= zero_lo && ticks <= zero_hi);
                shift_reg  = {one_bit, shift_reg[FRAME_BITS-1:1]};
                bits_taken = bits_taken + 1'b1;
                if (bits_taken >= FRAME_BITS)
                begin
                    f.address         = shift_reg[7:0];
                    f.address_inverse = shift_reg[15:8];
                    f.command         = shift_reg[23:16];
                    f.command_inverse = shift_reg[31:24];
                    f.frame_ok        = (f.address == ~f.address_inverse) &&
                                        (f.command == ~f.command_inverse);
                    frames_due.push_back(f);
                    dec_state  = DEC_IDLE;
                    bits_taken = '0;
                end
            end
            // idle and the unused encoding: this edge arms
            default:
            begin
                dec_state  = DEC_ARMED;
                bits_taken = '0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (mismatch_count < 10)
                $display("result %0d: %s expected %0h, got %0h",
                         frames_received, name, want, got);
            mismatch_count++;
        end
    endtask

    // sample all accepted transactions at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            zero_lo    = ZERO_MIN_RESET;
            zero_hi    = ZERO_MAX_RESET;
            leader_lo  = LEADER_MIN_RESET;
            leader_hi  = LEADER_MAX_RESET;
            dec_state  = DEC_IDLE;
            bits_taken = '0;
            shift_reg  = '0;
            frames_due.delete();
        end
        else
        begin
            // window writes, unknown indexes are dropped
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_ZERO_MIN:   zero_lo   = cfg_ch.data;
                    CFG_ZERO_MAX:   zero_hi   = cfg_ch.data;
                    CFG_LEADER_MIN: leader_lo = cfg_ch.data;
                    CFG_LEADER_MAX: leader_hi = cfg_ch.data;
                    default: ;
                endcase
            end

            if (edge_ch.valid && edge_ch.ready)
                decode_edge(edge_ch.edge_interval);

            // compare a result transaction with the oldest predicted frame
            if (result_ch.valid && result_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: %0h %0h %0h %0h ok %0b",
                                 result_ch.address, result_ch.address_inverse,
                                 result_ch.command, result_ch.command_inverse,
                                 result_ch.frame_ok);
                    mismatch_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("address", want.address, result_ch.address);
                    check_field("address_inverse", want.address_inverse,
                                result_ch.address_inverse);
                    check_field("command", want.command, result_ch.command);
                    check_field("command_inverse", want.command_inverse,
                                result_ch.command_inverse);
                    check_field("frame_ok", want.frame_ok, result_ch.frame_ok);
                end
                frames_received++;
            end
        end
        frames_pending = frames_due.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: drives edge intervals and window writes into the nec ir frame decoder
// and gives the verdict; prediction and comparison sit in nir_frame_checker
// depends on nir_pkg, nir_if, nir_frame_checker and nec_ir_frame_decoder_core
module testbench;
    import nir_pkg::*;

    localparam int unsigned TICK_MAX      = (1 << TICK_W) - 1;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned ITEM_TARGET   = 1200;
    localparam int unsigned FRAME_TARGET  = 40;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = CFG_LEADER_MAX + 1;

    logic clk = 1'b0;
    logic rst_n;

    nir_edge_if   edge_ch();
    nir_cfg_if    cfg_ch();
    nir_result_if result_ch();

    int unsigned mismatch_count;
    int unsigned frames_pending;
    int unsigned frames_received;

    // stimulus side copy of the windows, used only to shape intervals
    int unsigned win_zero_lo;
    int unsigned win_zero_hi;
    int unsigned win_leader_lo;
    int unsigned win_leader_hi;

    int unsigned edges_sent    = 0;
    int unsigned hold_requests = 0;
    bit          idling_on     = 1'b0;
    bit          decoder_armed = 1'b0;

    nec_ir_frame_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .edge_ch   (edge_ch),
        .cfg_ch    (cfg_ch),
        .result_ch (result_ch)
    );

    nir_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .edge_ch         (edge_ch),
        .cfg_ch          (cfg_ch),
        .result_ch       (result_ch),
        .mismatch_count  (mismatch_count),
        .frames_pending  (frames_pending),
        .frames_received (frames_received)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall cycle limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    // result ready: random stalls plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned holds_done;
        hold_left       = 0;
        holds_done      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(idling_on && $urandom_range(99) < 9);
        end
    end

    function automatic logic [TICK_W-1:0] pick_inside(input int unsigned lo,
                                                      input int unsigned hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // interval outside [lo, hi], biased to the borders; any value if none exists
    function automatic logic [TICK_W-1:0] pick_outside(input int unsigned lo,
                                                       input int unsigned hi);
        if (lo > hi)
            return $urandom_range(TICK_MAX, 0);
        if (lo != 0 && (hi == TICK_MAX || $urandom_range(1) == 1))
            return pick_inside(0, lo - 1);
        if (hi != TICK_MAX)
            return pick_inside(hi + 1, TICK_MAX);
        return $urandom_range(TICK_MAX, 0);
    endfunction

    function automatic logic [TICK_W-1:0] bit_ticks(input logic one_bit);
        if (!one_bit && win_zero_lo <= win_zero_hi)
            return pick_inside(win_zero_lo, win_zero_hi);
        if (one_bit)
            return pick_outside(win_zero_lo, win_zero_hi);
        return $urandom_range(TICK_MAX, 0);
    endfunction

    // one edge transaction, called and returning at a falling edge
    task automatic send_edge(input logic [TICK_W-1:0] ticks);
        if (idling_on && $urandom_range(99) < 9)
        begin
            edge_ch.valid <= 1'b0;
            @(negedge clk);
        end
        edge_ch.valid         <= 1'b1;
        edge_ch.edge_interval <= ticks;
        @(posedge clk);
        while (!edge_ch.ready) @(posedge clk);
        @(negedge clk);
        edges_sent++;
    endtask

    // leaves valid high so back to back writes follow without a gap
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [TICK_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted frame, then let the pipe empty
    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        while (frames_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_windows(input int unsigned zero_lo, input int unsigned zero_hi,
                               input int unsigned leader_lo, input int unsigned leader_hi);
        wait_drained();
        write_reg(CFG_ZERO_MIN, zero_lo);
        write_reg(CFG_ZERO_MAX, zero_hi);
        write_reg(CFG_LEADER_MIN, leader_lo);
        write_reg(CFG_LEADER_MAX, leader_hi);
        write_reg($urandom_range(8'hFF, FIRST_UNUSED_INDEX), $urandom);
        cfg_ch.valid <= 1'b0;
        win_zero_lo   = zero_lo;
        win_zero_hi   = zero_hi;
        win_leader_lo = leader_lo;
        win_leader_hi = leader_hi;
    endtask

    // arm edge when idle, leader, then the first bits of word, lsb first
    task automatic send_frame(input logic [FRAME_BITS-1:0] word,
                              input int unsigned bit_count);
        if (!decoder_armed)
            send_edge($urandom_range(TICK_MAX, 0));
        send_edge(pick_inside(win_leader_lo, win_leader_hi));
        for (int i = 0; i < bit_count; i++)
            send_edge(bit_ticks(word[i]));
        decoder_armed = 1'b0;
    endtask

    // mostly complete frames; noise and cut frames need a non leader interval to resync
    task automatic run_traffic(input int unsigned budget, input bit allow_noise);
        int unsigned           stop_at;
        int unsigned           pick;
        logic [BYTE_W-1:0]     addr;
        logic [BYTE_W-1:0]     cmd;
        logic [FRAME_BITS-1:0] word;
        stop_at = edges_sent + budget;
        while (edges_sent < stop_at)
        begin
            pick = $urandom_range(99);
            addr = $urandom;
            cmd  = $urandom;
            word = {~cmd, cmd, ~addr, addr};
            if (pick < 15)
                word[$urandom_range(FRAME_BITS - 1)] ^= 1'b1;
            else if (pick < 25)
                word = $urandom;
            if (!allow_noise || pick < 80)
                send_frame(word, FRAME_BITS);
            else
            begin
                if (pick < 90)
                    send_frame(word, $urandom_range(FRAME_BITS - 1, 0));
                else
                    repeat ($urandom_range(12, 1)) send_edge($urandom_range(TICK_MAX, 0));
                // 33 non leader edges always end up armed
                repeat (FRAME_BITS + 1) send_edge(pick_outside(win_leader_lo, win_leader_hi));
                decoder_armed = 1'b1;
            end
        end
    endtask

    // main stimulus
    initial
    begin
        logic [FRAME_BITS-1:0] word;
        int unsigned           base_a;
        int unsigned           base_b;

        rst_n                 = 1'b0;
        edge_ch.valid         = 1'b0;
        edge_ch.edge_interval = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        win_zero_lo           = ZERO_MIN_RESET;
        win_zero_hi           = ZERO_MAX_RESET;
        win_leader_lo         = LEADER_MIN_RESET;
        win_leader_hi         = LEADER_MAX_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: a leader value from idle only arms, then intervals around the leader window
        send_edge(LEADER_MIN_RESET);
        send_edge('0);
        send_edge(TICK_MAX);
        send_edge(LEADER_MIN_RESET - 1);
        send_edge(LEADER_MAX_RESET + 1);
        send_edge(LEADER_MAX_RESET);
        // frame bits on both borders of the zero window and at the field extremes
        word = $urandom;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            case (i)
                0:       send_edge(ZERO_MIN_RESET);
                1:       send_edge(ZERO_MAX_RESET);
                2:       send_edge(ZERO_MIN_RESET - 1);
                3:       send_edge(ZERO_MAX_RESET + 1);
                4:       send_edge('0);
                5:       send_edge(TICK_MAX);
                default: send_edge(bit_ticks(word[i]));
            endcase
        end

        // reset windows, no idling on either side
        run_traffic(300, 1'b1);

        // random ordinary windows with idling
        idling_on = 1'b1;
        base_a = $urandom_range(200000, 0);
        base_b = $urandom_range(8000000, 300000);
        set_windows(base_a, base_a + $urandom_range(150000, 0),
                    base_b, base_b + $urandom_range(500000, 0));
        run_traffic(300, 1'b1);

        // long result hold-off while edges keep coming, then wait for every frame
        hold_requests++;
        run_traffic(150, 1'b1);
        wait_drained();

        // empty zero window, leader window covers every interval
        set_windows(TICK_MAX, 0, 0, TICK_MAX);
        run_traffic(150, 1'b0);

        // full zero window, single value leader window
        base_b = $urandom_range(TICK_MAX, 0);
        set_windows(0, TICK_MAX, base_b, base_b);
        run_traffic(150, 1'b1);

        // empty leader window: nothing ever starts a frame
        set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, TICK_MAX, 0);
        repeat (20) send_edge($urandom_range(TICK_MAX, 0));
        decoder_armed = 1'b1;

        // back to reset windows until enough edges and frames
        set_windows(ZERO_MIN_RESET, ZERO_MAX_RESET, LEADER_MIN_RESET, LEADER_MAX_RESET);
        while (edges_sent < ITEM_TARGET || frames_received < FRAME_TARGET)
            run_traffic(100, 1'b1);

        wait_drained();
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: nec_ir_frame_decoder_core.f
rtl/core/nir_pkg.sv
rtl/core/nir_if.sv
rtl/core/nir_front.sv
rtl/core/nir_queue.sv
rtl/core/nir_back.sv
rtl/core/nec_ir_frame_decoder_core.sv
tb/nir_frame_checker.sv
tb/testbench.sv
